// ----- hdl/uf_pkg.sv -----
// ----------------------------------------------------------------------------
// uf_pkg
// shared types and constants of the disjoint-set engine
// ----------------------------------------------------------------------------
package uf_pkg;

  localparam int NODES  = 1024;
  localparam int IDX_W  = $clog2(NODES);
  localparam int STEP_W = $clog2(NODES + 1);
  localparam int ELEM_W = 10;
  localparam int RANK_W = 4;

  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  // operation codes
  localparam logic [1:0] MODE_MAKE_SET = 2'd0;
  localparam logic [1:0] MODE_FIND     = 2'd1;
  localparam logic [1:0] MODE_UNION    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK_UP,
    S_WALK_GP,
    S_RANK_A,
    S_RANK_B,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] data;
  } par_wr_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [RANK_W-1:0] data;
  } rank_wr_t;

  typedef struct packed {
    logic              valid;
    logic [ELEM_W-1:0] root;
    logic              merged;
  } result_t;

endpackage

// ----- hdl/uf_if.sv -----
// ----------------------------------------------------------------------------
// uf_if
// request and response channels of the disjoint-set engine
// ----------------------------------------------------------------------------
interface uf_req_if;
  import uf_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [ELEM_W-1:0] first_element;
  logic [ELEM_W-1:0] second_element;

  modport source (output valid, output mode, output first_element, output second_element,
                  input ready);
  modport sink   (input valid, input mode, input first_element, input second_element,
                  output ready);
endinterface

interface uf_rsp_if;
  import uf_pkg::*;

  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] root;
  logic              merged;

  modport source (output valid, output root, output merged, input ready);
  modport sink   (input valid, input root, input merged, output ready);
endinterface

// ----- hdl/uf_ram.sv -----
// ----------------------------------------------------------------------------
// uf_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module uf_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-first on an address collision
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/uf_ctrl.sv -----
// ----------------------------------------------------------------------------
// uf_ctrl
// sequencer: root walks with path halving, rank compare and link
// ----------------------------------------------------------------------------
module uf_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  uf_req_if.sink                   req,
  input  logic [uf_pkg::IDX_W-1:0]  par_rdata,
  input  logic [uf_pkg::RANK_W-1:0] rank_rdata,
  output logic [uf_pkg::IDX_W-1:0]  par_raddr,
  output logic [uf_pkg::IDX_W-1:0]  rank_raddr,
  output uf_pkg::par_wr_t          par_wr,
  output uf_pkg::rank_wr_t         rank_wr,
  output uf_pkg::result_t          res,
  input  logic                     res_ready
);
  import uf_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [IDX_W-1:0]  e;
  logic [IDX_W-1:0]  b_idx;
  logic [IDX_W-1:0]  ra;
  logic [RANK_W-1:0] rank_a;
  logic [STEP_W-1:0] steps;
  logic              is_union;
  logic              phase;
  logic [ELEM_W-1:0] res_root;
  logic              res_merged;

  logic              accept;
  logic [IDX_W-1:0]  a_in;
  logic [IDX_W-1:0]  b_in;
  logic              walk_done;

  assign accept    = req.valid && req.ready;
  assign a_in      = req.first_element[IDX_W-1:0];
  assign b_in      = req.second_element[IDX_W-1:0];
  assign walk_done = (steps == STEP_W'(NODES)) || (par_rdata == e);
  assign req.ready = (state == S_IDLE);

  assign res.valid  = (state == S_FINISH);
  assign res.root   = res_root;
  assign res.merged = res_merged;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if ((req.mode == MODE_FIND) || (req.mode == MODE_UNION)) begin
            state_next = S_WALK_UP;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_WALK_UP: begin
        if (!walk_done) begin
          state_next = S_WALK_GP;
        end else if (!is_union) begin
          state_next = S_FINISH;
        end else if (!phase) begin
          state_next = S_WALK_UP;
        end else if (e == ra) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_RANK_A;
        end
      end
      S_WALK_GP: state_next = S_WALK_UP;
      S_RANK_A:  state_next = S_RANK_B;
      S_RANK_B:  state_next = S_FINISH;
      S_FINISH: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    par_raddr  = e;
    rank_raddr = ra;
    par_wr     = '0;
    rank_wr    = '0;
    unique case (state)
      S_IDLE: begin
        par_raddr = a_in;
        if (accept && (req.mode == MODE_MAKE_SET)) begin
          par_wr  = '{we: 1'b1, addr: a_in, data: a_in};
          rank_wr = '{we: 1'b1, addr: a_in, data: '0};
        end
      end
      S_WALK_UP: begin
        if (!walk_done) begin
          par_raddr = par_rdata;
        end else if (is_union && !phase) begin
          par_raddr = b_idx;
        end
      end
      S_WALK_GP: begin
        // halve: point e at its grandparent and fetch the next parent
        par_wr    = '{we: 1'b1, addr: e, data: par_rdata};
        par_raddr = par_rdata;
      end
      S_RANK_A: rank_raddr = e;
      S_RANK_B: begin
        if (rank_a < rank_rdata) begin
          par_wr = '{we: 1'b1, addr: ra, data: e};
        end else begin
          par_wr = '{we: 1'b1, addr: e, data: ra};
          if ((rank_a == rank_rdata) && (rank_a != RANK_MAX)) begin
            rank_wr = '{we: 1'b1, addr: ra, data: rank_a + 1'b1};
          end
        end
      end
      S_FINISH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          is_union   <= (req.mode == MODE_UNION);
          phase      <= 1'b0;
          steps      <= '0;
          e          <= a_in;
          b_idx      <= b_in;
          res_merged <= 1'b0;
          res_root   <= (req.mode == MODE_MAKE_SET) ? ELEM_W'(a_in) : '0;
        end
      end
      S_WALK_UP: begin
        if (walk_done) begin
          if (!is_union) begin
            res_root <= ELEM_W'(e);
          end else if (!phase) begin
            ra    <= e;
            e     <= b_idx;
            phase <= 1'b1;
            steps <= '0;
          end else begin
            res_root <= ELEM_W'(ra);
          end
        end
      end
      S_WALK_GP: begin
        e     <= par_rdata;
        steps <= steps + 1'b1;
      end
      S_RANK_A: rank_a <= rank_rdata;
      S_RANK_B: begin
        res_merged <= 1'b1;
        res_root   <= (rank_a < rank_rdata) ? ELEM_W'(e) : ELEM_W'(ra);
      end
      S_FINISH: ;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_gp_follows_up: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_GP) |-> ($past(state) == S_WALK_UP))
    else $error("grandparent step without parent step");

  a_link_distinct: assert property (@(posedge clk) disable iff (rst)
    (state == S_RANK_B) |-> (e != ra))
    else $error("link of a root to itself");

  a_par_write_src: assert property (@(posedge clk) disable iff (rst)
    par_wr.we |-> ((state == S_WALK_GP) || (state == S_RANK_B) ||
                   ((state == S_IDLE) && accept && (req.mode == MODE_MAKE_SET))))
    else $error("unexpected parent table write");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == S_WALK_UP) || (state == S_WALK_GP)) |-> (steps <= STEP_W'(NODES)))
    else $error("walk step count beyond bound");

  a_merge_from_link: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINISH) && res_merged) |-> is_union)
    else $error("merge flagged on a non-union item");
`endif

endmodule

// ----- hdl/union_find_rank_halving_top.sv -----
// throughput: one item at a time; each walk step is a parent read then a grandparent read
// through the single read port of the parent table, so a request is taken once the
// previous response sits in the output register; reset clears control state only
// ----------------------------------------------------------------------------
// union_find_rank_halving_top
// disjoint-set engine with union by rank and path halving
// ----------------------------------------------------------------------------
module union_find_rank_halving_top (
  input logic    clk,
  input logic    rst,
  uf_req_if.sink   req,
  uf_rsp_if.source rsp
);
  import uf_pkg::*;

  // table ports
  logic [IDX_W-1:0]  par_raddr;
  logic [IDX_W-1:0]  par_rdata;
  logic [IDX_W-1:0]  rank_raddr;
  logic [RANK_W-1:0] rank_rdata;
  par_wr_t           par_wr;
  rank_wr_t          rank_wr;

  // finished result from the sequencer
  result_t           res;
  logic              res_ready;

  // output register
  logic              out_valid;
  logic [ELEM_W-1:0] out_root;
  logic              out_merged;

  // parent pointers, never cleared: make-set must write an entry before any read of it; the block does not enforce this
  uf_ram #(
    .DEPTH (NODES),
    .WIDTH (IDX_W)
  ) u_par_ram (
    .clk   (clk),
    .we    (par_wr.we),
    .waddr (par_wr.addr),
    .wdata (par_wr.data),
    .raddr (par_raddr),
    .rdata (par_rdata)
  );

  // ranks, read only when two distinct roots are linked
  uf_ram #(
    .DEPTH (NODES),
    .WIDTH (RANK_W)
  ) u_rank_ram (
    .clk   (clk),
    .we    (rank_wr.we),
    .waddr (rank_wr.addr),
    .wdata (rank_wr.data),
    .raddr (rank_raddr),
    .rdata (rank_rdata)
  );

  uf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .par_rdata  (par_rdata),
    .rank_rdata (rank_rdata),
    .par_raddr  (par_raddr),
    .rank_raddr (rank_raddr),
    .par_wr     (par_wr),
    .rank_wr    (rank_wr),
    .res        (res),
    .res_ready  (res_ready)
  );

  // slot is free when empty or being drained this cycle
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload holds while the response waits for its transfer
  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_root   <= res.root;
      out_merged <= res.merged;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.root   = out_root;
  assign rsp.merged = out_merged;

endmodule

// ----- tb/tb_union_find_rank_halving_top.sv -----
// ----------------------------------------------------------------------------
// tb_union_find_rank_halving_top
// self-checking bench for the disjoint-set engine: a behavioural copy of the
// parent and rank tables predicts every response. Directed checks come first,
// then a rank climb, then random make-set, find and union traffic.
// Random back-pressure and request gaps are applied on both channels.
// ----------------------------------------------------------------------------
module tb_union_find_rank_halving_top;
  timeunit 1ns;
  timeprecision 1ps;

  import uf_pkg::*;

  // mode code the engine leaves unused: no state change, zero response
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int      HALF_PERIOD_NS = 2;
  localparam int      RESET_CYCLES   = 11;
  localparam int      RANDOM_ITEMS   = 400;
  localparam int      REPORT_MAX     = 10;
  // longest union walk plus the rank reads, with margin
  localparam int      DRAIN_CYCLES   = 64;
  // watchdog bound for about 550 transfers, stalls included
  localparam longint  CYCLE_LIMIT    = 2_000_000;
  // rank levels of the binary counter climb, the survivor ends at this rank
  localparam int      CLIMB_LEVELS   = 5;
  localparam int      SPARE_BASE     = 960;
  localparam int      SPARE_COUNT    = 20;

  // one response as the engine should return it
  typedef struct packed {
    logic [ELEM_W-1:0] root;
    logic              merged;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  uf_req_if req ();
  uf_rsp_if rsp ();

  union_find_rank_halving_top uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // 4 ns period
  always #(HALF_PERIOD_NS) clk = ~clk;

  // behavioural copy of the engine tables
  logic [IDX_W-1:0]  parent_of [NODES];
  logic [RANK_W-1:0] rank_of   [NODES];

  // elements that make-set has written: only these may be found or joined
  bit                made      [NODES];
  logic [ELEM_W-1:0] made_q    [$];

  // responses still owed by the engine, oldest first
  outcome_t          pending_q [$];

  int     mismatch_count = 0;
  longint cycle_count    = 0;
  bit     pace_on        = 1'b1;
  int     stall_left     = 0;

  // ------------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------------

  // root walk with path halving: each visited node is pointed at its grandparent
  function automatic logic [IDX_W-1:0] walk_root(input logic [IDX_W-1:0] start);
    logic [IDX_W-1:0] node;
    logic [IDX_W-1:0] up;
    int               steps;
    node = start;
    for (steps = 0; steps < NODES; steps++) begin
      up = parent_of[node];
      if (up == node) break;
      parent_of[node] = parent_of[up];
      node = parent_of[node];
    end
    return node;
  endfunction

  function automatic outcome_t predict_op(input logic [1:0]        mode,
                                          input logic [ELEM_W-1:0] a,
                                          input logic [ELEM_W-1:0] b);
    outcome_t         res;
    logic [IDX_W-1:0] ra;
    logic [IDX_W-1:0] rb;
    res = '0;
    case (mode)
      MODE_MAKE_SET: begin
        parent_of[a] = a;
        rank_of[a]   = '0;
        res.root     = a;
      end
      MODE_FIND: begin
        res.root = walk_root(a);
      end
      MODE_UNION: begin
        ra = walk_root(a);
        rb = walk_root(b);
        res.root = ra;
        if (ra != rb) begin
          res.merged = 1'b1;
          if (rank_of[ra] < rank_of[rb]) begin
            // lower-ranked first root goes under the second
            parent_of[ra] = rb;
            res.root      = rb;
          end else begin
            parent_of[rb] = ra;
            // equal ranks: first root grows, saturating at the top rank
            if (rank_of[ra] == rank_of[rb] && rank_of[ra] != RANK_MAX)
              rank_of[ra] = rank_of[ra] + 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // pacing
  // ------------------------------------------------------------------------

  // mostly back to back, sometimes a short pause, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // response ready: held high, with random stalls while pacing is on
  always @(negedge clk) begin : rsp_ready_gen
    if (stall_left > 0) begin
      rsp.ready  <= 1'b0;
      stall_left  = stall_left - 1;
    end else begin
      rsp.ready <= 1'b1;
      if (pace_on && $urandom_range(0, 5) == 0) stall_left = pick_gap();
    end
  end

  // ------------------------------------------------------------------------
  // request driver
  // ------------------------------------------------------------------------

  // drive one request, wait for its transfer, then log what it should return;
  // valid stays high into the next call when there is no gap
  task automatic send_op(input logic [1:0]        mode,
                         input logic [ELEM_W-1:0] a,
                         input logic [ELEM_W-1:0] b);
    int gap;
    gap = pace_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      req.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req.valid          <= 1'b1;
    req.mode           <= mode;
    req.first_element  <= a;
    req.second_element <= b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_q.insert(pending_q.size(), predict_op(mode, a, b));
    if (mode == MODE_MAKE_SET && !made[a]) begin
      made[a] = 1'b1;
      made_q.insert(made_q.size(), a);
    end
  endtask

  // ------------------------------------------------------------------------
  // response checker
  // ------------------------------------------------------------------------

  always @(posedge clk) begin : rsp_check
    outcome_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_q.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= REPORT_MAX)
          $display("%0t: response with nothing outstanding: root %0d merged %0d",
                   $realtime, rsp.root, rsp.merged);
      end else begin
        want = pending_q.pop_front();
        if (rsp.root !== want.root || rsp.merged !== want.merged) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: mismatch: root exp %0d got %0d, merged exp %0d got %0d",
                     $realtime, want.root, rsp.root, want.merged, rsp.merged);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // field extremes, every mode, and each branch of the union
  task automatic test_directed();
    int i;
    int stride;
    send_op(MODE_MAKE_SET, 10'd0, 10'd1023);
    send_op(MODE_MAKE_SET, 10'd1023, 10'd0);
    send_op(MODE_FIND, 10'd1023, 10'd1023);
    send_op(MODE_UNUSED, 10'd1023, 10'd1023);

    // binomial tree of rank 3 over 16..23, deepest leaf 23 three levels down
    for (i = 16; i < 24; i++) send_op(MODE_MAKE_SET, i[ELEM_W-1:0], 10'd0);
    for (stride = 1; stride < 8; stride = stride * 2)
      for (i = 0; i < 8; i += 2 * stride)
        send_op(MODE_UNION, ELEM_W'(16 + i), ELEM_W'(16 + i + stride));

    // halving on the long path, then again on the shortened one
    send_op(MODE_FIND, 10'd23, 10'd1023);
    send_op(MODE_FIND, 10'd23, 10'd0);

    // lower-ranked root first, higher-ranked root first, same set
    send_op(MODE_UNION, 10'd0, 10'd23);
    send_op(MODE_UNION, 10'd16, 10'd1023);
    send_op(MODE_UNION, 10'd23, 10'd1023);

    // make-set of an inner node cuts it and its subtree loose
    send_op(MODE_MAKE_SET, 10'd20, 10'd1023);
    send_op(MODE_FIND, 10'd21, 10'd0);
    send_op(MODE_UNION, 10'd1023, 10'd1023);
    send_op(MODE_UNUSED, 10'd0, 10'd0);
  endtask

  // climb a binary counter of singleton roots until two roots of the top
  // climb level meet; each loser is cut free again by make-set so a handful
  // of elements suffice
  task automatic test_rank_climb();
    logic [ELEM_W-1:0] rank_holder  [CLIMB_LEVELS];
    bit                holder_valid [CLIMB_LEVELS];
    logic [ELEM_W-1:0] spare_q      [$];
    logic [ELEM_W-1:0] carry;
    int                level;
    int                i;
    bit                topped;
    pace_on = 1'b0;
    for (i = 0; i < CLIMB_LEVELS; i++) holder_valid[i] = 1'b0;
    for (i = 0; i < SPARE_COUNT; i++) begin
      send_op(MODE_MAKE_SET, ELEM_W'(SPARE_BASE + i), ELEM_W'($urandom_range(0, NODES - 1)));
      spare_q.insert(spare_q.size(), ELEM_W'(SPARE_BASE + i));
    end
    topped = 1'b0;
    while (!topped) begin
      carry = spare_q.pop_front();
      level = 0;
      while (!topped && holder_valid[level]) begin
        // equal ranks: the holder survives one rank up
        send_op(MODE_UNION, rank_holder[level], carry);
        send_op(MODE_MAKE_SET, carry, ELEM_W'($urandom_range(0, NODES - 1)));
        spare_q.insert(spare_q.size(), carry);
        if (level == CLIMB_LEVELS - 1) begin
          // two roots of the top climb level just met, survivor one rank up
          topped = 1'b1;
        end else begin
          carry               = rank_holder[level];
          holder_valid[level] = 1'b0;
          level++;
        end
      end
      if (!topped) begin
        rank_holder[level]  = carry;
        holder_valid[level] = 1'b1;
      end
    end
    // a fresh singleton must go under the climbed root
    carry = spare_q.pop_front();
    send_op(MODE_UNION, carry, rank_holder[CLIMB_LEVELS - 1]);
    send_op(MODE_FIND, carry, ELEM_W'($urandom_range(0, NODES - 1)));
    pace_on = 1'b1;
  endtask

  // random traffic over written elements, make-set clustered in a moving band
  // so that sets grow deep, with a little unused-mode noise
  task automatic test_random_ops();
    int                counted;
    int                iter;
    int                pick;
    int                band_base;
    logic [ELEM_W-1:0] a;
    logic [ELEM_W-1:0] b;
    counted   = 0;
    iter      = 0;
    band_base = 0;
    while (counted < RANDOM_ITEMS) begin
      if (iter % 64 == 0) begin
        // alternate paced stretches with back-to-back ones
        pace_on   = ($urandom_range(0, 3) != 0);
        band_base = $urandom_range(0, NODES - 128);
      end
      iter++;
      pick = $urandom_range(0, 99);
      b    = ELEM_W'($urandom_range(0, NODES - 1));
      if (pick < 6) begin
        a = ELEM_W'($urandom_range(0, NODES - 1));
        send_op(MODE_UNUSED, a, b);
      end else if (pick < 28) begin
        if ($urandom_range(0, 2) == 0) a = ELEM_W'($urandom_range(0, NODES - 1));
        else                           a = ELEM_W'(band_base + $urandom_range(0, 127));
        send_op(MODE_MAKE_SET, a, b);
        counted++;
      end else if (pick < 62) begin
        a = made_q[$urandom_range(0, made_q.size() - 1)];
        send_op(MODE_FIND, a, b);
        counted++;
      end else begin
        a = made_q[$urandom_range(0, made_q.size() - 1)];
        if ($urandom_range(0, 9) == 0) b = a;
        else                           b = made_q[$urandom_range(0, made_q.size() - 1)];
        send_op(MODE_UNION, a, b);
        counted++;
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------------

  initial begin
    req.valid          = 1'b0;
    req.mode           = MODE_MAKE_SET;
    req.first_element  = '0;
    req.second_element = '0;
    rsp.ready          = 1'b0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_rank_climb();
    test_random_ops();

    // let every owed response arrive, then watch for strays
    @(negedge clk);
    req.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
